[hw/rtl/sirap_pkg.sv]
package sirap_pkg;

  // Default sizes of the block.
  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_CHARS_DEF  = 64;

  // Register fields.
  localparam int RADIX_W   = 6;
  localparam int PAD_W     = 7;
  localparam int DIGIT_W   = RADIX_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = PAD_W;
  localparam int CHAR_W    = 8;

  localparam logic [CFG_IDX_W-1:0] REG_RADIX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAD   = 2'd1;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [PAD_W-1:0]   PAD_RESET   = 7'd0;

  localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_LETTER = 8'h37; // 'A' minus ten

  // Link between neighboring cells: one magnitude bit step and its carry.
  typedef struct packed {
    logic valid;
    logic carry;
  } cell_link_t;

  // Broadcast control to every cell.
  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_PAD,
    ST_SIGN,
    ST_DIGITS
  } state_e;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < 6'd10) begin
      return CHAR_ZERO + ext;
    end else begin
      return CHAR_LETTER + ext;
    end
  endfunction

endpackage

[hw/rtl/sirap_cell.sv]
// One digit position of the radix converter. During conversion the cell
// doubles its digit and adds the carry from the cell below, reducing by the
// radix when the sum reaches it; the reduction becomes the carry upward.
module sirap_cell import sirap_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cell_ctrl_t         ctrl_i,
  input  logic [RADIX_W-1:0] radix_i,
  input  cell_link_t         link_i,
  output cell_link_t         link_o,
  input  logic [DIGIT_W-1:0] digit_i,
  output logic [DIGIT_W-1:0] digit_o
);

  logic [DIGIT_W:0]   sum;
  logic [DIGIT_W:0]   diff;
  logic               ge;
  logic [DIGIT_W-1:0] digit_d, digit_q;
  cell_link_t         link_d, link_q;

  always_comb begin
    sum  = {digit_q, link_i.carry};
    ge   = sum >= {1'b0, radix_i};
    diff = sum - {1'b0, radix_i};
  end

  always_comb begin
    priority if (ctrl_i.clr) begin
      digit_d = '0;
    end else if (ctrl_i.shift) begin
      digit_d = digit_i;
    end else if (link_i.valid) begin
      digit_d = ge ? diff[DIGIT_W-1:0] : sum[DIGIT_W-1:0];
    end else begin
      digit_d = digit_q;
    end
    link_d.valid = link_i.valid & ~ctrl_i.clr;
    link_d.carry = link_i.valid & ge & ~ctrl_i.clr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= '0;
    end else begin
      link_q <= link_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign link_o  = link_q;
  assign digit_o = digit_q;

endmodule

[hw/rtl/signed_int_to_radix_ascii_padded.sv]
// Converts one signed integer per transfer into ASCII text in the base held
// in the radix register (2 to 36, digits 0-9 then A-Z), one character per
// output transfer, most significant first, with a leading '-' for negative
// values and leading spaces up to pad_width characters; last_char_o marks
// the final character. One value is handled at a time. After the input
// transfer the magnitude streams bit-serially through a row of VALUE_BITS
// digit cells, each cell one register behind its neighbor; a scan then
// shifts leading zero digits out of the top cell at one per cycle (up to
// VALUE_BITS-1 shifts) and then sizes the text, and finally one character
// leaves per cycle while the output is not stalled.
// Configuration writes are always ready and must be made while idle.
module signed_int_to_radix_ascii_padded import sirap_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_CHARS  = MAX_CHARS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CHAR_W-1:0]     ascii_char_o,
  output logic                  last_char_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DAT_W-1:0]  cfg_data_i
);

  // Base 2 of the most negative value needs one digit per value bit.
  localparam int NCELLS = VALUE_BITS;
  localparam int CNT_W  = $clog2(VALUE_BITS + NCELLS);
  localparam int SKIP_W = $clog2(NCELLS);
  localparam int DW     = $clog2(NCELLS + 1);
  localparam int LEN_W  = $clog2(NCELLS + 2);
  localparam int TW     = (PAD_W > LEN_W) ? PAD_W : LEN_W;
  localparam logic [CNT_W-1:0]  CONV_LAST = CNT_W'(VALUE_BITS + NCELLS - 2);
  localparam logic [SKIP_W-1:0] SKIP_LAST = SKIP_W'(NCELLS - 1);

  // Configuration registers.
  logic [RADIX_W-1:0] radix_d, radix_q;
  logic [PAD_W-1:0]   pad_width_d, pad_width_q;
  logic [RADIX_W-1:0] cfg_radix;
  logic [PAD_W-1:0]   cfg_pad;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_radix = cfg_data_i[RADIX_W-1:0];
    cfg_pad   = cfg_data_i[PAD_W-1:0];
    radix_d     = radix_q;
    pad_width_d = pad_width_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == REG_RADIX) begin
        priority if (cfg_radix < RADIX_MIN) begin
          radix_d = RADIX_MIN;
        end else if (cfg_radix > RADIX_MAX) begin
          radix_d = RADIX_MAX;
        end else begin
          radix_d = cfg_radix;
        end
      end else if (cfg_index_i == REG_PAD) begin
        // Writes above the character limit saturate to it.
        if (int'(cfg_pad) > MAX_CHARS) begin
          pad_width_d = PAD_W'(MAX_CHARS);
        end else begin
          pad_width_d = cfg_pad;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q     <= RADIX_RESET;
      pad_width_q <= PAD_RESET;
    end else begin
      radix_q     <= radix_d;
      pad_width_q <= pad_width_d;
    end
  end

  // Sequencer and datapath registers.
  state_e                state_d, state_q;
  logic                  neg_d, neg_q;
  logic [VALUE_BITS-1:0] mag_d, mag_q;
  logic [CNT_W-1:0]      cnt_d, cnt_q;
  logic [SKIP_W-1:0]     skip_d, skip_q;
  logic [DW-1:0]         dig_rem_d, dig_rem_q;
  logic [PAD_W-1:0]      pad_rem_d, pad_rem_q;
  logic                  out_valid_d, out_valid_q;
  logic [CHAR_W-1:0]     char_d, char_q;
  logic                  last_d, last_q;

  logic                  in_accept;
  logic                  out_load;
  logic                  scan_skip;
  logic [DW-1:0]         dig_len;
  logic [TW-1:0]         text_len;
  logic [TW-1:0]         pad_ext;
  logic [PAD_W-1:0]      pad_len;

  // Cell row: index 0 is the feed from the magnitude shifter and the zero
  // fill for upward shifts; index NCELLS is the most significant digit.
  cell_ctrl_t            cell_ctrl;
  cell_link_t            link_w [NCELLS+1];
  logic [DIGIT_W-1:0]    dig_w  [NCELLS+1];
  logic [DIGIT_W-1:0]    top_digit;

  assign dig_w[0]  = '0;
  assign top_digit = dig_w[NCELLS];

  // The magnitude enters the row most significant bit first.
  assign link_w[0].valid = (state_q == ST_CONV) && (cnt_q < CNT_W'(VALUE_BITS));
  assign link_w[0].carry = mag_q[VALUE_BITS-1];

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    sirap_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .radix_i (radix_q),
      .link_i  (link_w[i]),
      .link_o  (link_w[i+1]),
      .digit_i (dig_w[i]),
      .digit_o (dig_w[i+1])
    );
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && (state_q == ST_IDLE);
  assign out_load   = !out_valid_q || !out_stall_i;

  // Leading zeros are dropped from the top, keeping at least one digit.
  always_comb begin
    scan_skip = (top_digit == '0) && (skip_q != SKIP_LAST);
    dig_len   = DW'(NCELLS) - DW'(skip_q);
    text_len  = TW'(dig_len) + TW'(neg_q);
    pad_ext   = TW'(pad_width_q);
    pad_len   = (pad_ext > text_len) ? PAD_W'(pad_ext - text_len) : '0;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CONV;
      end
      ST_CONV: begin
        if (cnt_q == CONV_LAST) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (!scan_skip) begin
          if (pad_len != '0) begin
            state_d = ST_PAD;
          end else begin
            state_d = neg_q ? ST_SIGN : ST_DIGITS;
          end
        end
      end
      ST_PAD: begin
        if (out_load && (pad_rem_q == PAD_W'(1))) state_d = neg_q ? ST_SIGN : ST_DIGITS;
      end
      ST_SIGN: begin
        if (out_load) state_d = ST_DIGITS;
      end
      ST_DIGITS: begin
        if (out_load && (dig_rem_q == DW'(1))) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    neg_d       = neg_q;
    mag_d       = mag_q;
    cnt_d       = cnt_q;
    skip_d      = skip_q;
    dig_rem_d   = dig_rem_q;
    pad_rem_d   = pad_rem_q;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    cell_ctrl   = '0;

    if (out_load) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          neg_d         = value_i[VALUE_BITS-1];
          // Negating the most negative value leaves 2^(VALUE_BITS-1) unsigned.
          mag_d         = value_i[VALUE_BITS-1] ? (~value_i + 1'b1) : value_i;
          cnt_d         = '0;
          skip_d        = '0;
          cell_ctrl.clr = 1'b1;
        end
      end
      ST_CONV: begin
        mag_d = mag_q << 1;
        cnt_d = cnt_q + 1'b1;
      end
      ST_SCAN: begin
        if (scan_skip) begin
          cell_ctrl.shift = 1'b1;
          skip_d          = skip_q + 1'b1;
        end else begin
          dig_rem_d = dig_len;
          pad_rem_d = pad_len;
        end
      end
      ST_PAD: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          char_d      = CHAR_SPACE;
          last_d      = 1'b0;
          pad_rem_d   = pad_rem_q - 1'b1;
        end
      end
      ST_SIGN: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          char_d      = CHAR_MINUS;
          last_d      = 1'b0;
        end
      end
      ST_DIGITS: begin
        if (out_load) begin
          out_valid_d     = 1'b1;
          char_d          = digit_char(top_digit);
          last_d          = (dig_rem_q == DW'(1));
          dig_rem_d       = dig_rem_q - 1'b1;
          cell_ctrl.shift = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      skip_q      <= '0;
      dig_rem_q   <= '0;
      pad_rem_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      skip_q      <= skip_d;
      dig_rem_q   <= dig_rem_d;
      pad_rem_q   <= pad_rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    mag_q  <= mag_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign ascii_char_o = char_q;
  assign last_char_o  = last_q;

endmodule

[tb/sv/radix_text_checker.sv]
module radix_text_checker import sirap_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_CHARS  = MAX_CHARS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [CHAR_W-1:0]     ascii_char_i,
  input  logic                  last_char_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DAT_W-1:0]  cfg_data_i,
  output int                    errors_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CHAR_W-1:0] GLYPH_A = 8'h41;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              is_last;
  } text_char_t;

  logic [RADIX_W-1:0] radix_q;
  logic [PAD_W-1:0]   pad_q;
  logic [RADIX_W-1:0] radix_raw;
  text_char_t         text_q[$];
  text_char_t         want;
  int                 fail_count;

  // Appends the characters expected for one value under the current registers.
  function automatic void predict_text(input logic [VALUE_BITS-1:0] raw);
    logic [CHAR_W-1:0]     rev[$];
    logic [VALUE_BITS-1:0] mag;
    longint unsigned       rest;
    int unsigned           digit, pad_n, total, k;
    text_char_t            c;
    mag  = raw[VALUE_BITS-1] ? -raw : raw;
    rest = 64'(mag);
    do begin
      digit = int'(rest % 64'(radix_q));
      rev.push_back((digit < 10) ? CHAR_ZERO + CHAR_W'(digit) : GLYPH_A + CHAR_W'(digit - 10));
      rest = rest / 64'(radix_q);
    end while (rest != 0);
    if (raw[VALUE_BITS-1]) begin
      rev.push_back(CHAR_MINUS);
    end
    pad_n = (int'(pad_q) > rev.size()) ? int'(pad_q) - rev.size() : 0;
    total = pad_n + rev.size();
    for (k = 0; k < total; k++) begin
      c.ch      = (k < pad_n) ? CHAR_SPACE : rev[rev.size() - 1 - (k - pad_n)];
      c.is_last = (k + 1 == total);
      text_q.push_back(c);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q    = RADIX_RESET;
      pad_q      = PAD_RESET;
      fail_count = 0;
      text_q.delete();
    end else begin
      // Compare the outgoing character first, so that a value accepted on the
      // same edge never shadows what is still owed for the previous one.
      if (out_valid_i && !out_stall_i) begin
        if (text_q.size() == 0) begin
          $error("unexpected character: ascii_char 8'h%02h last_char %0b",
                 ascii_char_i, last_char_i);
          fail_count++;
        end else begin
          want = text_q.pop_front();
          if (ascii_char_i !== want.ch) begin
            $error("ascii_char: expected 8'h%02h, got 8'h%02h", want.ch, ascii_char_i);
            fail_count++;
          end
          if (last_char_i !== want.is_last) begin
            $error("last_char: expected %0b, got %0b", want.is_last, last_char_i);
            fail_count++;
          end
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_RADIX: begin
            radix_raw = cfg_data_i[RADIX_W-1:0];
            if (radix_raw < RADIX_MIN) begin
              radix_q = RADIX_MIN;
            end else if (radix_raw > RADIX_MAX) begin
              radix_q = RADIX_MAX;
            end else begin
              radix_q = radix_raw;
            end
          end
          REG_PAD: begin
            pad_q = (int'(cfg_data_i) > MAX_CHARS) ? PAD_W'(MAX_CHARS) : cfg_data_i;
          end
          default: begin
            // Indexes past the register list change nothing.
          end
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        predict_text(value_i);
      end
    end
    errors_o  = fail_count;
    pending_o = text_q.size();
  end

endmodule

[tb/sv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sirap_pkg::*;

  localparam int VW = VALUE_BITS_DEF;

  // Indexes that fall past the register list; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 54;
  // Long output hold-off, long enough for the block to back up into its input.
  localparam int HOLD_CYCLES  = 300;
  // The worst case covers the conversion and the scan plus up to 64 characters.
  localparam int DRAIN_CYCLES = 200;
  // Longest quiet stretch in a correct run is the hold-off plus one
  // conversion plus a long sender gap, well under this limit.
  localparam int IDLE_LIMIT   = 4000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [VW-1:0]        value_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [CHAR_W-1:0]    ascii_char_o;
  logic                 last_char_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;

  int   errors;
  int   pending;
  logic quiet;
  int   hold_asks;
  int   hold_done;

  logic in_fire, out_fire, cfg_fire;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_o && !out_stall_i;
  assign cfg_fire = cfg_valid_i && cfg_ready_o;

  signed_int_to_radix_ascii_padded u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .ascii_char_o (ascii_char_o),
    .last_char_o  (last_char_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // The checker sits beside the block, sees every transfer on all three
  // channels, and keeps its own copy of the two registers.
  radix_text_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .value_i      (value_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .ascii_char_i (ascii_char_o),
    .last_char_i  (last_char_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Idle stretches: mostly short, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 9) < 8) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(8, 40);
    end
  endfunction

  // Random values lean toward the interesting corners: extremes, small
  // magnitudes around zero, and magnitudes of every bit length.
  function automatic logic [VW-1:0] pick_value();
    logic [VW-1:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom();
      2: v = $urandom_range(0, 100) - 50;
      3: begin
        case ($urandom_range(0, 5))
          0: v = '0;
          1: v = '1;
          2: v = 32'h0000_0001;
          3: v = 32'h7FFF_FFFF;
          4: v = 32'h8000_0000;
          default: v = 32'h8000_0001;
        endcase
      end
      default: begin
        v = $urandom() >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) begin
          v = -v;
        end
      end
    endcase
    return v;
  endfunction

  // One input transfer. The task is entered just after a rising edge and
  // returns just after the edge that accepted the value. With no gap the
  // valid simply stays high for the next value.
  task automatic send_value(input logic [VW-1:0] v);
    int gap;
    gap = quiet ? 0 : (($urandom_range(0, 1) == 0) ? 0 : gap_len());
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
  endtask

  // Stops offering values and waits until every expected character has
  // been seen. Every value produces at least one character, so the block is
  // idle once the count reaches zero.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // One register write; only called while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // The receiver decides its stall at each falling edge. A hold-off request
  // from the stimulus takes priority over new random stalls and keeps the output
  // stalled for a long stretch while the sender keeps offering values.
  initial begin : receiver
    int stall_left;
    stall_left  = 0;
    hold_done   = 0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (hold_done != hold_asks) begin
        hold_done++;
        stall_left = HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        stall_left = gap_len() - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Ends the run if no transfer of any kind happens for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (in_fire || out_fire || cfg_fire) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    logic [CFG_DAT_W-1:0] radix_set;
    logic [CFG_DAT_W-1:0] pad_set;
    int p, i;
    in_valid_i  = 1'b0;
    value_i     = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_RADIX;
    cfg_data_i  = '0;
    quiet       = 1'b0;
    hold_asks   = 0;
    rst_ni      = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Plain decimal with the reset settings: zero, both ends of the range,
    // and ordinary values of either sign.
    send_value(32'h0000_0000);
    send_value(32'h0000_0001);
    send_value(32'hFFFF_FFFF);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'h1234_5678);
    send_value(-32'sd123456789);
    drain();

    // A radix write of zero must saturate to binary and an oversized pad
    // width to the character limit. Writes past the register list must leave
    // both registers alone.
    write_reg(REG_RADIX, 7'd0);
    write_reg(REG_PAD, 7'h7F);
    write_reg(REG_SPARE_A, 7'h7F);
    write_reg(REG_SPARE_B, 7'h2A);
    send_value(32'h8000_0000);
    send_value(32'hFFFF_FFFF);
    send_value(32'h7FFF_FFFF);
    send_value(32'h0000_0000);
    drain();

    // A radix above thirty-six saturates; a pad width just past the limit
    // saturates and is then replaced by a short one.
    write_reg(REG_RADIX, 7'd63);
    write_reg(REG_PAD, 7'd65);
    write_reg(REG_PAD, 7'd5);
    send_value(32'h8000_0000);
    send_value(32'd35);
    send_value(-32'sd35);
    send_value(32'd36);
    send_value(32'h7FFF_FFFF);
    drain();

    // A radix of one saturates up to two; pad width exactly at the limit.
    write_reg(REG_RADIX, 7'd1);
    write_reg(REG_PAD, 7'd64);
    send_value(-32'sd5);
    send_value(32'd2);
    drain();

    // Radix just past the top, no padding.
    write_reg(REG_RADIX, 7'd37);
    write_reg(REG_PAD, 7'd0);
    send_value(32'h8000_0000);
    send_value(-32'sd1295);
    drain();

    // Random phases. The first two pin the extremes of both registers, the next two
    // use fixed middle settings, the rest take raw register values, saturating ones
    // included, with mostly short pad widths. Every third phase runs with no idling.
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin radix_set = 7'd2;  pad_set = 7'd0;  end
        1: begin radix_set = 7'd36; pad_set = 7'd64; end
        2: begin radix_set = 7'd16; pad_set = 7'd12; end
        3: begin radix_set = 7'd8;  pad_set = 7'd40; end
        default: begin
          radix_set = CFG_DAT_W'($urandom_range(0, 127));
          pad_set   = ($urandom_range(0, 3) == 0) ? CFG_DAT_W'($urandom_range(0, 127))
                                                  : CFG_DAT_W'($urandom_range(0, 10));
        end
      endcase
      write_reg(REG_RADIX, radix_set);
      write_reg(REG_PAD, pad_set);
      quiet <= (p % 3 == 2);
      if (p == 2) begin
        hold_asks <= hold_asks + 1;
      end
      for (i = 0; i < PHASE_ITEMS; i++) begin
        send_value(pick_value());
      end
      drain();
    end

    // Give a misbehaving block time to emit anything it still holds.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/sirap_pkg.sv
hw/rtl/sirap_cell.sv
hw/rtl/signed_int_to_radix_ascii_padded.sv
tb/sv/radix_text_checker.sv
tb/sv/tb.sv
